// ----- hdl/ppp_pkg.sv -----
// Shared types, constants and helper functions of the pixel plot engine.
package ppp_pkg;

  localparam int ScreenLinesDef  = 256;
  localparam int WordsPerLineDef = 64;

  // Width used for coordinate range compares (covers widths up to 1024).
  localparam int CoordCmpW = 12;

  localparam logic [15:0] Clr4Mask = 16'h0101;
  localparam logic [15:0] Clr8Mask = 16'h0303;
  localparam logic [15:0] Sel8Mask = 16'h0203;
  localparam logic [7:0]  MapMaxIndex = 8'd15;

  typedef enum logic [1:0] {
    OP_RAW_WRITE = 2'd0,
    OP_MAP_WRITE = 2'd1,
    OP_READ      = 2'd2,
    OP_NONE      = 2'd3
  } ppp_op_e;

  typedef enum logic [1:0] {
    ST_CLEAR  = 2'd0,
    ST_IDLE   = 2'd1,
    ST_UPDATE = 2'd2
  } ppp_state_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [8:0] x;
    logic [8:0] y;
    logic [7:0] colour;
  } ppp_in_t;

  typedef struct packed {
    logic [2:0]  read_colour;
    logic [15:0] pixel_bits;
    logic        range_error;
  } ppp_out_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic update;
  } ppp_cmd_t;

  typedef struct packed {
    logic clear_last;
  } ppp_status_t;

  // Fixed colour map over indexes 0 to 15 (8 to 15 repeat 0 to 7); indexes above 15 give black.
  function automatic logic [2:0] map_colour(input logic [7:0] idx);
    logic [1:0] m;
    m = 2'd0;
    case (idx[2:0])
      3'd0:    m = 2'd0;
      3'd1:    m = 2'd2;
      3'd2:    m = 2'd2;
      3'd3:    m = 2'd2;
      3'd4:    m = 2'd1;
      3'd5:    m = 2'd1;
      3'd6:    m = 2'd1;
      3'd7:    m = 2'd3;
      default: m = 2'd0;
    endcase
    if (idx > MapMaxIndex) begin
      m = 2'd0;
    end
    return {1'b0, m};
  endfunction

endpackage

// ----- hdl/planar_pixel_plot_engine.sv -----
// Top level of the pixel plot engine: controller and datapath joined.
// The accept step registers a word and reads its screen word; the update step then
// writes that screen word back and registers the result and its strobe. A new word
// is not taken until the update step of the last one is through.
// Reset: screen_mode returns to zero and busy stays high while a sweep clears every
// screen word; the receiver cannot stall.
module planar_pixel_plot_engine #(
  parameter int SCREEN_LINES   = ppp_pkg::ScreenLinesDef,
  parameter int WORDS_PER_LINE = ppp_pkg::WordsPerLineDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Command side: a word is taken when start is high and busy is low.
  input  logic              start,
  output logic              busy,
  input  ppp_pkg::ppp_in_t  item_i,
  // Result side: valid for exactly one cycle, never held off.
  output logic              result_valid_o,
  output ppp_pkg::ppp_out_t result_o,
  // Mode register write; the user must write it only while the engine is idle (not enforced).
  input  logic              cfg_we_i,
  input  logic              cfg_data_i
);

  ppp_pkg::ppp_cmd_t    cmd;
  ppp_pkg::ppp_status_t status;

  // The controller sequences the clearing sweep, accepts commands and
  // triggers the read-modify-write step that follows each accepted word.
  ppp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // The datapath decodes coordinates into a word address and masks, holds
  // the screen memory and the mode register, and registers the result.
  ppp_dpath #(
    .SCREEN_LINES   (SCREEN_LINES),
    .WORDS_PER_LINE (WORDS_PER_LINE)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .item_i         (item_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

// ----- hdl/ppp_ctrl.sv -----
// Controller state machine of the pixel plot engine.
module ppp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  ppp_pkg::ppp_status_t status_i,
  output ppp_pkg::ppp_cmd_t    cmd_o
);

  ppp_pkg::ppp_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ppp_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ppp_pkg::ST_CLEAR: begin
        if (status_i.clear_last) begin
          state_d = ppp_pkg::ST_IDLE;
        end
      end
      ppp_pkg::ST_IDLE: begin
        if (start) begin
          state_d = ppp_pkg::ST_UPDATE;
        end
      end
      ppp_pkg::ST_UPDATE: begin
        state_d = ppp_pkg::ST_IDLE;
      end
      default: state_d = ppp_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    case (state_q)
      ppp_pkg::ST_CLEAR: begin
        cmd_o.clear = 1'b1;
      end
      ppp_pkg::ST_IDLE: begin
        busy         = 1'b0;
        cmd_o.accept = start;
      end
      ppp_pkg::ST_UPDATE: begin
        cmd_o.update = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

endmodule

// ----- hdl/ppp_dpath.sv -----
// Datapath of the pixel plot engine: address and mask logic plus screen memory.
module ppp_dpath #(
  parameter int SCREEN_LINES   = ppp_pkg::ScreenLinesDef,
  parameter int WORDS_PER_LINE = ppp_pkg::WordsPerLineDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_data_i,
  input  ppp_pkg::ppp_in_t     item_i,
  input  ppp_pkg::ppp_cmd_t    cmd_i,
  output ppp_pkg::ppp_status_t status_o,
  output logic                 result_valid_o,
  output ppp_pkg::ppp_out_t    result_o
);

  localparam int Depth = SCREEN_LINES * WORDS_PER_LINE;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW    = ppp_pkg::CoordCmpW;

  logic [15:0] mem [Depth];

  logic          mode_q;
  logic [AW-1:0] clr_addr_q;

  // Item captured at accept.
  logic [1:0]    op_q;
  logic [2:0]    pos_q;
  logic [2:0]    col_q;
  logic          err_q;
  logic          mode_item_q;
  logic [AW-1:0] addr_q;
  logic [15:0]   rd_q;

  ppp_pkg::ppp_out_t res_q;
  logic              valid_q;

  // Address and range decode on the incoming item.
  logic [CW-1:0] x_wide, y_wide;
  logic          x_ok, y_ok, err_d;
  logic [6:0]    col_idx;
  logic [AW-1:0] addr_d;
  logic [2:0]    pos_d;
  logic [2:0]    colour_d;

  always_comb begin
    x_wide  = CW'(item_i.x);
    y_wide  = CW'(item_i.y);
    x_ok    = mode_q ? (x_wide < CW'(WORDS_PER_LINE * 4)) : (x_wide < CW'(WORDS_PER_LINE * 8));
    y_ok    = y_wide < CW'(SCREEN_LINES);
    err_d   = !(x_ok && y_ok);
    col_idx = mode_q ? item_i.x[8:2] : {1'b0, item_i.x[8:3]};
    addr_d  = AW'(item_i.y) * AW'(WORDS_PER_LINE) + AW'(col_idx);
    pos_d   = mode_q ? {~item_i.x[1:0], 1'b0} : ~item_i.x[2:0];
    if (item_i.operation == ppp_pkg::OP_MAP_WRITE) begin
      colour_d = ppp_pkg::map_colour(item_i.colour);
    end else begin
      colour_d = item_i.colour[2:0];
    end
  end

  // Masks and new word for the captured item.
  logic [15:0] clr_mask, sel_mask, set_bits, shifted, new_word;
  logic [2:0]  rc;
  logic        do_write, is_read;

  always_comb begin
    if (mode_item_q) begin
      clr_mask = ppp_pkg::Clr8Mask << pos_q;
      sel_mask = ppp_pkg::Sel8Mask << pos_q;
      set_bits = ({14'd0, col_q[1:0]} << pos_q)
               | ({15'd0, col_q[2]} << (4'(pos_q) + 4'd9));
      shifted  = rd_q >> pos_q;
      rc       = {shifted[9], shifted[1:0]};
    end else begin
      clr_mask = ppp_pkg::Clr4Mask << pos_q;
      sel_mask = clr_mask;
      set_bits = ({15'd0, col_q[0]} << pos_q)
               | ({15'd0, col_q[1]} << {1'b1, pos_q});
      shifted  = rd_q >> pos_q;
      rc       = {1'b0, shifted[8], shifted[0]};
    end
    new_word = (rd_q & ~clr_mask) | set_bits;
    do_write = cmd_i.update && !err_q
             && (op_q == ppp_pkg::OP_RAW_WRITE || op_q == ppp_pkg::OP_MAP_WRITE);
    is_read  = !err_q && (op_q == ppp_pkg::OP_READ);
  end

  // Single write port shared by the clearing sweep and pixel updates.
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [15:0]   mem_wd;

  always_comb begin
    mem_we = cmd_i.clear || do_write;
    mem_wa = cmd_i.clear ? clr_addr_q : addr_q;
    mem_wd = cmd_i.clear ? 16'd0 : new_word;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd_i.accept) begin
      rd_q <= mem[addr_d];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q        <= item_i.operation;
      pos_q       <= pos_d;
      col_q       <= colour_d;
      err_q       <= err_d && (item_i.operation != ppp_pkg::OP_NONE);
      mode_item_q <= mode_q;
      addr_q      <= addr_d;
    end
    if (cmd_i.update) begin
      res_q.read_colour <= is_read ? rc : 3'd0;
      res_q.pixel_bits  <= is_read ? (rd_q & sel_mask) : 16'd0;
      res_q.range_error <= err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 1'b0;
      clr_addr_q <= '0;
      valid_q    <= 1'b0;
    end else begin
      valid_q <= cmd_i.update;
      if (cfg_we_i) begin
        mode_q <= cfg_data_i;
      end
      if (cmd_i.clear) begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
    end
  end

  assign status_o.clear_last = (clr_addr_q == AW'(Depth - 1));
  assign result_valid_o      = valid_q;
  assign result_o            = res_q;

endmodule
